/* sv/msbl_pkg.sv */
// Package for the multi-slot bounded list store.
// Holds sizes, command, status and state codes and the word types of both channels.
// No dependencies.
package msbl_pkg;

  localparam int SLOTS       = 10;
  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;

  localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int DEPTH  = SLOTS * CAPACITY;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic signed [VALUE_WIDTH-1:0] val_t;

  // Command codes.
  localparam logic [2:0] CMD_CREATE = 3'd0;
  localparam logic [2:0] CMD_APPEND = 3'd1;
  localparam logic [2:0] CMD_POP    = 3'd2;
  localparam logic [2:0] CMD_REMOVE = 3'd3;
  localparam logic [2:0] CMD_RESIZE = 3'd4;
  localparam logic [2:0] CMD_COUNT  = 3'd5;
  localparam logic [2:0] CMD_READ   = 3'd6;
  localparam logic [2:0] CMD_SORTED = 3'd7;

  // Status codes.
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_BAD_SLOT  = 4'd1;
  localparam logic [3:0] ST_EXISTS    = 4'd2;
  localparam logic [3:0] ST_BAD_SIZE  = 4'd3;
  localparam logic [3:0] ST_NO_MEM    = 4'd4;
  localparam logic [3:0] ST_FULL      = 4'd5;
  localparam logic [3:0] ST_NO_LIST   = 4'd6;
  localparam logic [3:0] ST_EMPTY     = 4'd7;
  localparam logic [3:0] ST_NOT_FOUND = 4'd8;
  localparam logic [3:0] ST_BAD_NEW   = 4'd9;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_RM_RD, S_RM_CMP, S_SH_RD, S_SH_WR,
    S_RD_RD, S_RD_OUT, S_SR_RD, S_SR_CMP, S_SR_OUT, S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]        command;
    logic [3:0]        slot;
    logic signed [31:0] value;
    logic signed [7:0]  amount;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         status;
    logic signed [31:0] element;
    logic               element_valid;
    logic [6:0]         count;
    logic               last;
  } out_word_t;

  // Element store address of entry idx of slot s.
  function automatic logic [ADDR_W-1:0] mem_addr(input logic [SIDX_W-1:0] s,
                                                 input logic [IDX_W-1:0] idx);
    mem_addr = ADDR_W'(int'(s) * CAPACITY + int'(idx));
  endfunction

endpackage

/* sv/msbl_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module msbl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/multi_slot_bounded_list_store.sv */
// Top level of the multi-slot bounded list store.
// Depends on msbl_pkg and msbl_ram.
//
// The block keeps SLOTS numbered lists over one element memory with a
// registered read port; slot flags, capacities and fill counts sit in
// flip-flops. One command is worked at a time. Create, append, pop, resize,
// count and bad-slot commands pass through the execute and done states.
// Remove reads and compares each element searched, then reads and writes
// each element moved down. Read reads and emits each element in turn. Sorted
// read rescans the list once per result word through the memory read port.
// Result words sit in an output register, so a stalled consumer only holds the
// command that is emitting.
module multi_slot_bounded_list_store
  import msbl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  state_t state, state_next;

  logic [2:0]        cmd;
  logic [3:0]        slot;
  val_t              val;
  logic signed [7:0] amt;
  logic [3:0]        st;

  logic present [SLOTS];
  cnt_t cap     [SLOTS];
  cnt_t fill    [SLOTS];

  cnt_t i, k, bidx, pidx;
  val_t bval, pval;
  logic have_best, have_prev;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  val_t              wdata, rdata;

  logic              slot_ok;
  logic [SIDX_W-1:0] s;
  logic              cur_present;
  cnt_t              cur_fill, cur_cap;
  logic signed [8:0] new_cap;
  logic              can_emit, emit;
  out_word_t         emit_word;
  logic              accept;
  logic              match, above_prev, better;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign can_emit = !out_valid || out_ready;

  // Slot decode and live table read.
  assign slot_ok     = (slot != 4'd0) && (int'(slot) <= SLOTS);
  assign s           = SIDX_W'(slot - 4'd1);
  assign cur_present = slot_ok && present[s];
  assign cur_fill    = slot_ok ? fill[s] : '0;
  assign cur_cap     = slot_ok ? cap[s] : '0;
  assign new_cap     = $signed({4'b0, cur_cap}) + 9'(amt);

  // Element comparisons for search and sorted read.
  assign match      = (rdata == val);
  assign above_prev = !have_prev || (rdata > pval) || ((rdata == pval) && (i > pidx));
  assign better     = !have_best || (rdata < bval);

  msbl_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_DONE;
        if (cur_present) begin
          if (cmd == CMD_REMOVE && cur_fill != '0) state_next = S_RM_RD;
          if (cmd == CMD_READ && cur_fill != '0) state_next = S_RD_RD;
          if (cmd == CMD_SORTED && cur_fill != '0) state_next = S_SR_RD;
        end
      end
      S_RM_RD: state_next = S_RM_CMP;
      S_RM_CMP: begin
        if (match) begin
          state_next = (i + cnt_t'(1) < cur_fill) ? S_SH_RD : S_DONE;
        end else begin
          state_next = (i + cnt_t'(1) == cur_fill) ? S_DONE : S_RM_RD;
        end
      end
      S_SH_RD: state_next = S_SH_WR;
      S_SH_WR: state_next = (i + cnt_t'(2) < cur_fill) ? S_SH_RD : S_DONE;
      S_RD_RD: state_next = S_RD_OUT;
      S_RD_OUT: begin
        if (can_emit) begin
          state_next = (i + cnt_t'(1) == cur_fill) ? S_IDLE : S_RD_RD;
        end
      end
      S_SR_RD: state_next = S_SR_CMP;
      S_SR_CMP: state_next = (i + cnt_t'(1) == cur_fill) ? S_SR_OUT : S_SR_RD;
      S_SR_OUT: begin
        if (can_emit) begin
          state_next = (k + cnt_t'(1) == cur_fill) ? S_IDLE : S_SR_RD;
        end
      end
      S_DONE: begin
        if (can_emit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory controls and result words.
  always_comb begin
    we        = 1'b0;
    waddr     = mem_addr(s, i[IDX_W-1:0]);
    wdata     = val;
    raddr     = mem_addr(s, i[IDX_W-1:0]);
    emit      = 1'b0;
    emit_word = '0;
    unique case (state)
      S_EXEC: begin
        if (cur_present && cmd == CMD_APPEND && cur_fill < cur_cap) begin
          we    = 1'b1;
          waddr = mem_addr(s, cur_fill[IDX_W-1:0]);
        end
      end
      S_SH_RD: raddr = mem_addr(s, IDX_W'(i + cnt_t'(1)));
      S_SH_WR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      S_RD_OUT: begin
        emit                    = can_emit;
        emit_word.status        = ST_OK;
        emit_word.element       = 32'(rdata);
        emit_word.element_valid = 1'b1;
        emit_word.count         = 7'(cur_fill);
        emit_word.last          = (i + cnt_t'(1) == cur_fill);
      end
      S_SR_OUT: begin
        emit                    = can_emit;
        emit_word.status        = ST_OK;
        emit_word.element       = 32'(bval);
        emit_word.element_valid = 1'b1;
        emit_word.count         = 7'(cur_fill);
        emit_word.last          = (k + cnt_t'(1) == cur_fill);
      end
      S_DONE: begin
        emit            = can_emit;
        emit_word.status = st;
        emit_word.count = 7'(cur_fill);
        emit_word.last  = 1'b1;
      end
      default: ;
    endcase
  end

  // State register and slot table.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int n = 0; n < SLOTS; n++) begin
        present[n] <= 1'b0;
        cap[n]     <= '0;
        fill[n]    <= '0;
      end
    end else begin
      state <= state_next;
      if (state == S_EXEC && slot_ok) begin
        if (cmd == CMD_CREATE) begin
          if (!present[s] && amt >= 8'sd1 && int'(amt) <= CAPACITY) begin
            present[s] <= 1'b1;
            cap[s]     <= cnt_t'(amt);
            fill[s]    <= '0;
          end
        end else if (present[s]) begin
          case (cmd)
            CMD_APPEND: if (cur_fill < cur_cap) fill[s] <= cur_fill + cnt_t'(1);
            CMD_POP:    if (cur_fill != '0) fill[s] <= cur_fill - cnt_t'(1);
            CMD_RESIZE: begin
              if (new_cap >= 9'sd1 && int'(new_cap) <= CAPACITY) begin
                cap[s] <= cnt_t'(new_cap);
                if (int'(cur_fill) > int'(new_cap)) fill[s] <= cnt_t'(new_cap);
              end
            end
            default: ;
          endcase
        end
      end
      // Removal shrinks the list once the gap is closed.
      if ((state == S_RM_CMP && match && !(i + cnt_t'(1) < cur_fill)) ||
          (state == S_SH_WR && !(i + cnt_t'(2) < cur_fill))) begin
        fill[s] <= cur_fill - cnt_t'(1);
      end
    end
  end

  // Command capture, status and walk registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd  <= in_data.command;
      slot <= in_data.slot;
      val  <= val_t'(in_data.value);
      amt  <= in_data.amount;
    end
    case (state)
      S_EXEC: begin
        i         <= '0;
        k         <= '0;
        have_best <= 1'b0;
        have_prev <= 1'b0;
        st        <= ST_OK;
        if (!slot_ok) begin
          st <= ST_BAD_SLOT;
        end else if (cmd == CMD_CREATE) begin
          if (cur_present) st <= ST_EXISTS;
          else if (amt < 8'sd1) st <= ST_BAD_SIZE;
          else if (int'(amt) > CAPACITY) st <= ST_NO_MEM;
        end else if (!cur_present) begin
          st <= ST_NO_LIST;
        end else begin
          case (cmd)
            CMD_APPEND: if (cur_fill >= cur_cap) st <= ST_FULL;
            CMD_POP, CMD_REMOVE, CMD_COUNT: if (cur_fill == '0) st <= ST_EMPTY;
            CMD_RESIZE: begin
              if (new_cap < 9'sd1) st <= ST_BAD_NEW;
              else if (int'(new_cap) > CAPACITY) st <= ST_NO_MEM;
            end
            default: ;
          endcase
        end
      end
      S_RM_CMP: begin
        if (!match) begin
          i <= i + cnt_t'(1);
          if (i + cnt_t'(1) == cur_fill) st <= ST_NOT_FOUND;
        end
      end
      S_SH_WR: i <= i + cnt_t'(1);
      S_RD_OUT: if (can_emit) i <= i + cnt_t'(1);
      S_SR_CMP: begin
        if (above_prev && better) begin
          bval      <= rdata;
          bidx      <= i;
          have_best <= 1'b1;
        end
        if (i + cnt_t'(1) != cur_fill) i <= i + cnt_t'(1);
      end
      S_SR_OUT: begin
        if (can_emit) begin
          pval      <= bval;
          pidx      <= bidx;
          have_prev <= 1'b1;
          have_best <= 1'b0;
          k         <= k + cnt_t'(1);
          i         <= '0;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (emit) out_data <= emit_word;
  end

  // A waiting result word is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !emit)
    else $error("result word overwritten while waiting");

  // An accepted command is decoded in the next cycle.
  a_exec_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC))
    else $error("accepted command not decoded");

  // A present slot never holds more elements than its capacity.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && cur_present) |-> (cur_fill <= cur_cap))
    else $error("fill count above capacity");

endmodule

/* tb/tb.sv */
// Testbench for the multi-slot bounded list store.
// Depends on msbl_pkg and multi_slot_bounded_list_store; a scoreboard class
// predicts the result words of each accepted command and checks them in order.
`timescale 1ns / 1ps

module tb;
  import msbl_pkg::*;

  // Predictor of the list store with a queue of pending result words.
  class list_scoreboard;
    bit            present [SLOTS];
    int            cap [SLOTS];
    int            fill [SLOTS];
    logic [31:0]   store [SLOTS][CAPACITY];
    out_word_t     pending [$];
    int            mismatches;

    function void push_word(logic [3:0] st, logic [31:0] e, bit v, int c, bit l);
      out_word_t w;
      w.status = st;
      w.element = e;
      w.element_valid = v;
      w.count = 7'(c);
      w.last = l;
      pending.push_back(w);
    endfunction

    // Notes one accepted command and queues the words it causes.
    function void note_command(in_word_t w);
      int s, i, j, n, amt, nc;
      logic [3:0] st;
      logic [31:0] buf_q [CAPACITY];
      logic [31:0] x;
      st = ST_OK;
      amt = int'(w.amount);
      if (w.slot < 1 || w.slot > SLOTS) begin
        push_word(ST_BAD_SLOT, 0, 0, 0, 1);
        return;
      end
      s = int'(w.slot) - 1;
      if (w.command == CMD_CREATE) begin
        if (present[s]) st = ST_EXISTS;
        else if (amt < 1) st = ST_BAD_SIZE;
        else if (amt > CAPACITY) st = ST_NO_MEM;
        else begin
          present[s] = 1;
          cap[s] = amt;
          fill[s] = 0;
        end
      end else if (!present[s]) begin
        st = ST_NO_LIST;
      end else if (w.command == CMD_APPEND) begin
        if (fill[s] >= cap[s]) st = ST_FULL;
        else begin
          store[s][fill[s]] = w.value;
          fill[s]++;
        end
      end else if (w.command == CMD_POP) begin
        if (fill[s] == 0) st = ST_EMPTY;
        else fill[s]--;
      end else if (w.command == CMD_REMOVE) begin
        if (fill[s] == 0) st = ST_EMPTY;
        else begin
          i = 0;
          while (i < fill[s] && store[s][i] != w.value) i++;
          if (i == fill[s]) st = ST_NOT_FOUND;
          else begin
            for (; i + 1 < fill[s]; i++) store[s][i] = store[s][i+1];
            fill[s]--;
          end
        end
      end else if (w.command == CMD_RESIZE) begin
        nc = cap[s] + amt;
        if (nc < 1) st = ST_BAD_NEW;
        else if (nc > CAPACITY) st = ST_NO_MEM;
        else begin
          cap[s] = nc;
          if (fill[s] > nc) fill[s] = nc;
        end
      end else if (w.command == CMD_COUNT) begin
        if (fill[s] == 0) st = ST_EMPTY;
      end else begin
        n = fill[s];
        for (i = 0; i < n; i++) buf_q[i] = store[s][i];
        // Ascending read: insertion sort on signed values.
        if (w.command == CMD_SORTED) begin
          for (i = 1; i < n; i++) begin
            x = buf_q[i];
            j = i;
            while (j > 0 && $signed(buf_q[j-1]) > $signed(x)) begin
              buf_q[j] = buf_q[j-1];
              j--;
            end
            buf_q[j] = x;
          end
        end
        if (n == 0) push_word(ST_OK, 0, 0, 0, 1);
        for (i = 0; i < n; i++) push_word(ST_OK, buf_q[i], 1, fill[s], i + 1 == n);
        return;
      end
      push_word(st, 0, 0, fill[s], 1);
    endfunction

    // Compares one accepted result word with the oldest expectation.
    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("expected no word, got %h", got);
        return;
      end
      exp_w = pending.pop_front();
      if (got.status !== exp_w.status || got.element !== exp_w.element ||
          got.element_valid !== exp_w.element_valid || got.count !== exp_w.count ||
          got.last !== exp_w.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected st=%0d el=%0d v=%0d cnt=%0d last=%0d,",
                    " got st=%0d el=%0d v=%0d cnt=%0d last=%0d"},
                   exp_w.status, exp_w.element, exp_w.element_valid, exp_w.count,
                   exp_w.last, got.status, got.element, got.element_valid,
                   got.count, got.last);
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 0;
  out_word_t out_data;

  list_scoreboard board = new();
  bit  calm = 0;
  bit  hold_off = 0;
  int  cycles = 0;

  always #1 clk = ~clk;

  multi_slot_bounded_list_store DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  // Acceptance monitor on both channels.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_command(in_data);
      if (out_valid && out_ready) board.check_word(out_data);
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off, none at the end.
  initial begin
    int k;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 0;
        for (k = 0; k < 3000; k++) @(posedge clk);
        hold_off = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Offers one word and waits until it is accepted, with random gaps first.
  task automatic send_word(logic [2:0] c, logic [3:0] s, logic [31:0] v, logic [7:0] a);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{command: c, slot: s, value: v, amount: a};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 6)) - 32'd3;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int i, c, s;
    logic [31:0] pool [8];
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: bad slots, create checks, fill to full, every command, extremes.
    send_word(CMD_COUNT, 4'd0, 0, 0);
    send_word(CMD_APPEND, 4'd15, 32'hffff_ffff, 8'h7f);
    send_word(CMD_APPEND, 4'd1, 5, 0);
    send_word(CMD_CREATE, 4'd1, 0, 8'd0);
    send_word(CMD_CREATE, 4'd1, 0, 8'h80);
    send_word(CMD_CREATE, 4'd1, 0, 8'd17);
    send_word(CMD_CREATE, 4'd1, 0, 8'd2);
    send_word(CMD_CREATE, 4'd1, 0, 8'd2);
    send_word(CMD_COUNT, 4'd1, 0, 0);
    send_word(CMD_READ, 4'd1, 0, 0);
    send_word(CMD_POP, 4'd1, 0, 0);
    send_word(CMD_REMOVE, 4'd1, 0, 0);
    send_word(CMD_APPEND, 4'd1, 32'h7fff_ffff, 0);
    send_word(CMD_APPEND, 4'd1, 32'h8000_0000, 0);
    send_word(CMD_APPEND, 4'd1, 1, 0);
    send_word(CMD_SORTED, 4'd1, 0, 0);
    send_word(CMD_REMOVE, 4'd1, 9, 0);
    send_word(CMD_RESIZE, 4'd1, 0, 8'hfe);
    send_word(CMD_RESIZE, 4'd1, 0, 8'd15);
    send_word(CMD_RESIZE, 4'd1, 0, 8'hff);
    send_word(CMD_RESIZE, 4'd1, 0, 8'd14);
    send_word(CMD_CREATE, 4'd10, 0, 8'd16);
    for (i = 0; i < 3; i++) send_word(CMD_APPEND, 4'd10, $urandom, 0);
    send_word(CMD_REMOVE, 4'd1, 32'h7fff_ffff, 0);

    // Long receiver hold-off while commands keep coming.
    hold_off = 1;
    for (i = 0; i < 12; i++) send_word(CMD_READ, 4'd10, 0, 0);

    // Random part: mostly valid slots, values from a small pool so that
    // removals find matches.
    for (i = 0; i < 8; i++) pool[i] = rand_value();
    for (i = 0; i < 280; i++) begin
      if (i == 230) calm = 1;
      c = $urandom_range(0, 9);
      if (c > 7) c = 1;
      s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 10);
      send_word(3'(c), 4'(s),
                ($urandom_range(0, 3) == 0) ? rand_value() : pool[$urandom_range(0, 7)],
                ($urandom_range(0, 7) == 0) ? 8'($urandom) :
                8'($urandom_range(0, 40) - 20));
    end
    in_valid <= 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
